// ===== rtl/core/wsfd_pkg.sv =====
// Shared types and constants for the websocket frame deframer.
package wsfd_pkg;

    // Result kinds as seen on the output ports.
    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_CLOSED = 2'd2,
        KIND_BADLEN = 2'd3
    } t_kind;

    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Classified input word handed from the front to the back.
    typedef struct packed {
        logic       close;
        logic [7:0] data;
    } t_tok;

    // One result word.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic       last_in_frame;
    } t_res;

endpackage

// ===== rtl/core/websocket_frame_deframer_core.sv =====
// Each word is registered in the front queue and its result in the result queue.
// Throughput: one input word per cycle, sustained, while results are popped each cycle.
// The front queue holds four words and the result queue two, so either side may stall alone.
// Reset is synchronous and active low; it empties both queues, returns the parser to the
// first header byte with cleared length and key, and sets the enable register to one.
module websocket_frame_deframer_core #(
    parameter int TOK_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic       i_command,
    input  logic [7:0] i_wire_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_payload_byte,
    output logic       o_last_in_frame
);

    wsfd_pkg::t_tok tok;
    logic           tok_empty;
    logic           tok_take;
    wsfd_pkg::t_res res;

    wsfd_front #(
        .TOK_DEPTH (TOK_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_command   (i_command),
        .i_wire_byte (i_wire_byte),
        .o_tok       (tok),
        .o_tok_empty (tok_empty),
        .i_tok_take  (tok_take)
    );

    wsfd_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok),
        .i_tok_empty (tok_empty),
        .o_tok_take  (tok_take),
        .o_res       (res),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

    assign o_kind          = res.kind;
    assign o_payload_byte  = res.payload_byte;
    assign o_last_in_frame = res.last_in_frame;

endmodule

// ===== rtl/core/wsfd_fifo.sv =====
// Small register-based first-in first-out queue with the head shown combinationally.
module wsfd_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr;
    logic             rd;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr        = i_wr_en && !o_full;
    assign rd        = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== rtl/core/wsfd_front.sv =====
// Front end: accepts input words, drops them while disabled and queues them for the parser.
module wsfd_front #(
    parameter int TOK_DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_push,
    output logic            o_full,
    input  logic            i_command,
    input  logic [7:0]      i_wire_byte,
    output wsfd_pkg::t_tok  o_tok,
    output logic            o_tok_empty,
    input  logic            i_tok_take
);

    logic           r_enabled;
    wsfd_pkg::t_tok tok_in;
    logic           tok_wr;
    logic [$bits(wsfd_pkg::t_tok)-1:0] tok_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            r_enabled <= i_cfg_wdata;
        end
    end

    // A disabled block still takes the word but forgets it.
    assign tok_in.close = i_command;
    assign tok_in.data  = i_wire_byte;
    assign tok_wr       = i_push && r_enabled;

    wsfd_fifo #(
        .WIDTH ($bits(wsfd_pkg::t_tok)),
        .DEPTH (TOK_DEPTH)
    ) u_tok_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (tok_wr),
        .i_wr_data (tok_in),
        .o_full    (o_full),
        .i_rd_en   (i_tok_take),
        .o_rd_data (tok_rd_data),
        .o_empty   (o_tok_empty)
    );

    assign o_tok = wsfd_pkg::t_tok'(tok_rd_data);

endmodule

// ===== rtl/core/wsfd_back.sv =====
// Back end: frame header parser and payload unmasking, feeding the result queue.
module wsfd_back #(
    parameter int RES_DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wsfd_pkg::t_tok  i_tok,
    input  logic            i_tok_empty,
    output logic            o_tok_take,
    output wsfd_pkg::t_res  o_res,
    output logic            o_res_empty,
    input  logic            i_res_pop
);

    typedef enum logic [3:0] {
        PH_HDR0    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_EXT_HI  = 4'd2,
        PH_EXT_LO  = 4'd3,
        PH_KEY0    = 4'd4,
        PH_KEY1    = 4'd5,
        PH_KEY2    = 4'd6,
        PH_KEY3    = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_STALL   = 4'd9
    } t_phase;

    t_phase         r_phase,      n_phase;
    logic           r_is_text,    n_is_text;
    logic           r_is_masked,  n_is_masked;
    logic [15:0]    r_bytes_left, n_bytes_left;
    logic [31:0]    r_mask_key,   n_mask_key;
    logic [1:0]     r_key_index,  n_key_index;

    wsfd_pkg::t_res res;
    logic           res_wr;
    logic           res_full;
    logic           take;
    logic           after_len;
    logic           hdr_done;
    logic [7:0]     key_byte;
    logic [6:0]     len_code;
    logic [$bits(wsfd_pkg::t_res)-1:0] res_rd_data;

    // The parser only moves when the result queue can take whatever it produces.
    assign take       = !i_tok_empty && !res_full;
    assign o_tok_take = take;
    assign len_code   = i_tok.data[6:0];

    always_comb begin
        case (r_key_index)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_is_text    = r_is_text;
        n_is_masked  = r_is_masked;
        n_bytes_left = r_bytes_left;
        n_mask_key   = r_mask_key;
        n_key_index  = r_key_index;
        res          = '0;
        res_wr       = 1'b0;
        after_len    = 1'b0;
        hdr_done     = 1'b0;
        if (take) begin
            if (i_tok.close) begin
                n_phase      = PH_HDR0;
                n_is_text    = 1'b0;
                n_is_masked  = 1'b0;
                n_bytes_left = '0;
                n_mask_key   = '0;
                n_key_index  = '0;
                res_wr       = 1'b1;
                res.kind     = wsfd_pkg::KIND_CLOSED;
            end else begin
                unique case (r_phase)
                    PH_HDR0: begin
                        n_is_text = (i_tok.data[3:0] == wsfd_pkg::OPC_TEXT);
                        n_phase   = PH_HDR1;
                    end
                    PH_HDR1: begin
                        n_is_masked = i_tok.data[7];
                        if (len_code == wsfd_pkg::LEN_EXT16) begin
                            n_phase = PH_EXT_HI;
                        end else if (len_code == wsfd_pkg::LEN_EXT64) begin
                            n_phase  = PH_STALL;
                            res_wr   = 1'b1;
                            res.kind = wsfd_pkg::KIND_BADLEN;
                        end else begin
                            n_bytes_left = {9'd0, len_code};
                            after_len    = 1'b1;
                        end
                    end
                    PH_EXT_HI: begin
                        n_bytes_left = {i_tok.data, 8'd0};
                        n_phase      = PH_EXT_LO;
                    end
                    PH_EXT_LO: begin
                        n_bytes_left = {r_bytes_left[15:8], i_tok.data};
                        after_len    = 1'b1;
                    end
                    PH_KEY0: begin
                        n_mask_key = {r_mask_key[23:0], i_tok.data};
                        n_phase    = PH_KEY1;
                    end
                    PH_KEY1: begin
                        n_mask_key = {r_mask_key[23:0], i_tok.data};
                        n_phase    = PH_KEY2;
                    end
                    PH_KEY2: begin
                        n_mask_key = {r_mask_key[23:0], i_tok.data};
                        n_phase    = PH_KEY3;
                    end
                    PH_KEY3: begin
                        n_mask_key = {r_mask_key[23:0], i_tok.data};
                        hdr_done   = 1'b1;
                    end
                    PH_PAYLOAD: begin
                        n_bytes_left = r_bytes_left - 16'd1;
                        n_key_index  = r_key_index + 2'd1;
                        if (r_bytes_left == 16'd1) begin
                            n_phase = PH_HDR0;
                        end
                        if (r_is_text) begin
                            res_wr            = 1'b1;
                            res.kind          = wsfd_pkg::KIND_BYTE;
                            res.payload_byte  = r_is_masked ? (i_tok.data ^ key_byte)
                                                            : i_tok.data;
                            res.last_in_frame = (r_bytes_left == 16'd1);
                        end
                    end
                    default: begin
                        // Stalled after an unsupported length: wait for a close.
                    end
                endcase
                if (after_len) begin
                    if (n_is_masked) begin
                        n_phase = PH_KEY0;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
                if (hdr_done) begin
                    n_key_index = '0;
                    if (n_bytes_left == '0) begin
                        n_phase = PH_HDR0;
                        if (r_is_text) begin
                            res_wr   = 1'b1;
                            res.kind = wsfd_pkg::KIND_EMPTY;
                        end
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR0;
            r_is_text    <= 1'b0;
            r_is_masked  <= 1'b0;
            r_bytes_left <= '0;
            r_mask_key   <= '0;
            r_key_index  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_is_text    <= n_is_text;
            r_is_masked  <= n_is_masked;
            r_bytes_left <= n_bytes_left;
            r_mask_key   <= n_mask_key;
            r_key_index  <= n_key_index;
        end
    end

    wsfd_fifo #(
        .WIDTH ($bits(wsfd_pkg::t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_wr),
        .i_wr_data (res),
        .o_full    (res_full),
        .i_rd_en   (i_res_pop),
        .o_rd_data (res_rd_data),
        .o_empty   (o_res_empty)
    );

    assign o_res = wsfd_pkg::t_res'(res_rd_data);

    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_bytes_left != 16'd0))
        else $error("payload phase entered with no bytes left");

    a_close_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_tok.close) |=> (r_phase == PH_HDR0 && r_bytes_left == 16'd0))
        else $error("close did not return the parser to the first header byte");

    a_stall_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_tok.close && r_phase == PH_STALL) |-> !res_wr)
        else $error("stalled parser produced a result for a data word");

    a_key_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_tok.close && r_phase == PH_KEY3 && n_phase == PH_PAYLOAD)
        |=> (r_key_index == 2'd0))
        else $error("payload started with a nonzero key index");

endmodule
